[sv/rtpjb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtpjb_pkg
// Types, codes and helpers shared by the RTP jitter / reorder buffer.
// ----------------------------------------------------------------------------
package rtpjb_pkg;

   localparam logic [1:0] KIND_RELEASE = 2'd0;
   localparam logic [1:0] KIND_REPORT  = 2'd1;
   localparam logic [1:0] KIND_DROP    = 2'd2;

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic CSR_TIMEOUT    = 1'b0;
   localparam logic CSR_REPORT_GAP = 1'b1;

   localparam logic [15:0] DROPOUT_LIMIT   = 16'd3000;
   localparam logic [16:0] MISORDER_BOUND  = 17'd65436;  // span minus misorder limit
   localparam logic [16:0] SUSPECT_RESET   = 17'd65537;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
   localparam logic [15:0] REPORT_GAP_RESET = 16'd500;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RPT,
      ST_REL_ITEM,
      ST_CLASSIFY,
      ST_SWEEP,
      ST_STORE,
      ST_CHAIN_ACT,
      ST_SCAN_ACT,
      ST_SCAN_RPT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SW_CHAIN,
      SW_SCAN,
      SW_LOOKUP
   } sweep_mode_type;

   typedef struct packed {
      logic [47:0] seq;
      logic [15:0] tag;
      logic [31:0] arrival;
   } slot_entry_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] ext_seq;
      logic [15:0] tag;
   } emit_type;

   typedef struct packed {
      logic     emit;
      logic     finish;
      emit_type data;
   } emit_ctl_type;

   // wrapping difference read as signed, then compared to a limit
   function automatic logic elapsed_over(input logic [31:0] now_t,
                                         input logic [31:0] then_t,
                                         input logic [15:0] limit);
      logic [31:0] d;
      d = now_t - then_t;
      return !d[31] && (d > {16'd0, limit});
   endfunction

endpackage
`default_nettype wire

[sv/rtpjb_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtpjb_req_if / rtpjb_rsp_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rtpjb_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] seq;
   logic [15:0] packet_tag;
   logic [31:0] now_ms;

   modport source (output valid, operation, seq, packet_tag, now_ms, input ready);
   modport sink   (input valid, operation, seq, packet_tag, now_ms, output ready);
endinterface

interface rtpjb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [47:0] ext_seq;
   logic [15:0] out_tag;
   logic        last;

   modport source (output valid, kind, ext_seq, out_tag, last, input ready);
   modport sink   (input valid, kind, ext_seq, out_tag, last, output ready);
endinterface
`default_nettype wire

[sv/rtpjb_emit_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtpjb_emit_stage
// Holds one result back until the next one (or the end of the item) shows
// whether it is the last, then moves it to the output register.
// ----------------------------------------------------------------------------
module rtpjb_emit_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rtpjb_pkg::emit_ctl_type ctl,
   output logic                       ok,
   rtpjb_rsp_if.source                rsp
);
   import rtpjb_pkg::*;

   logic     pend_v_ff, pend_v_in;
   emit_type pend_ff, pend_in;
   logic     out_v_ff, out_v_in;
   emit_type out_ff, out_in;
   logic     out_last_ff, out_last_in;
   logic     move;

   assign ok   = !pend_v_ff || !out_v_ff || rsp.ready;
   assign move = pend_v_ff && (ctl.emit || ctl.finish) && ok;

   always_comb begin
      out_v_in    = out_v_ff && !rsp.ready;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      if (move) begin
         out_v_in    = 1'b1;
         out_in      = pend_ff;
         out_last_in = ctl.finish;
      end
      if (ctl.emit && ok) begin
         pend_v_in = 1'b1;
         pend_in   = ctl.data;
      end else if (ctl.finish && ok) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid   = out_v_ff;
   assign rsp.kind    = out_ff.kind;
   assign rsp.ext_seq = out_ff.ext_seq;
   assign rsp.out_tag = out_ff.tag;
   assign rsp.last    = out_last_ff;

endmodule
`default_nettype wire

[sv/rtp_jitter_reorder_buffer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_jitter_reorder_buffer
// RTP sequence extension with a small reorder store and timeout release.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Held packets sit in a slot memory with a
// registered read; every ordered search walks all STORE_DEPTH slots in one
// pass. An in-order packet with nothing held makes one pass. A tick makes one
// pass per held entry plus one, each followed by an action state, and by a
// report state for a timed-out entry; a stored packet first adds a lookup
// pass. The worst case is a store into a full set of entries that all time
// out. A result waiting on a stalled output holds the sequencer and adds its
// wait. No clearing pass follows reset.
module rtp_jitter_reorder_buffer #(
   parameter int STORE_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   rtpjb_req_if.sink        req,
   rtpjb_rsp_if.source      rsp,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   import rtpjb_pkg::*;

   localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam logic [CW-1:0] CNT_END = CW'(STORE_DEPTH);

   state_type      state_ff, state_in;
   logic           started_ff, started_in;
   logic [15:0]    highest_ff, highest_in;
   logic [16:0]    suspect_ff, suspect_in;
   logic [31:0]    wrap_ff, wrap_in;
   logic [47:0]    released_ff, released_in;
   logic [31:0]    last_rpt_ff, last_rpt_in;
   logic [15:0]    timeout_ff, gap_ff;
   logic [STORE_DEPTH-1:0] valid_ff, valid_in;

   logic           op_ff;
   logic [15:0]    seq_ff, tag_ff;
   logic [31:0]    now_ff;
   logic [47:0]    ext_ff, ext_in;
   logic           chain_ff, chain_in;
   sweep_mode_type mode_ff, mode_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           rdv_ff, rdv_in;
   logic [IW-1:0]  rdidx_ff, rdidx_in;
   logic           best_v_ff, best_v_in;
   logic [IW-1:0]  best_idx_ff, best_idx_in;
   slot_entry_type best_ff, best_in;
   logic           use_bound_ff, use_bound_in;
   logic [47:0]    bound_ff, bound_in;

   slot_entry_type slot_mem [STORE_DEPTH];
   slot_entry_type rd_ff;
   logic           rd_en;
   logic           wr_en;
   logic [IW-1:0]  wr_idx;
   slot_entry_type wr_data;

   logic           accept;
   logic [15:0]    udelta;
   logic [31:0]    wrap_new;
   logic [47:0]    rel_next;
   logic           rpt_ok, tmo, sweep_done, stall;
   logic           free_v;
   logic [IW-1:0]  free_idx;
   emit_ctl_type   ctl;
   logic           q_ok;

   assign accept     = req.valid && req.ready;
   assign req.ready  = (state_ff == ST_IDLE);
   assign udelta     = seq_ff - highest_ff;
   assign wrap_new   = wrap_ff + ((seq_ff < highest_ff) ? 32'd1 : 32'd0);
   assign rel_next   = released_ff + 48'd1;
   assign rpt_ok     = elapsed_over(now_ff, last_rpt_ff, gap_ff);
   assign tmo        = elapsed_over(now_ff, best_ff.arrival, timeout_ff);
   assign sweep_done = (cnt_ff == CNT_END) && !rdv_ff;
   assign rd_en      = (state_ff == ST_SWEEP) && (cnt_ff != CNT_END);

   always_comb begin
      free_v   = 1'b0;
      free_idx = '0;
      for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_v   = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   // result requests toward the output stage
   always_comb begin
      ctl        = '0;
      ctl.finish = (state_ff == ST_FINISH);
      unique case (state_ff)
         ST_RPT: begin
            ctl.emit = rpt_ok;
            ctl.data = '{KIND_REPORT, ext_ff, tag_ff};
         end
         ST_REL_ITEM: begin
            ctl.emit = 1'b1;
            ctl.data = '{KIND_RELEASE, ext_ff, tag_ff};
         end
         ST_STORE: begin
            ctl.emit = !best_v_ff && !free_v;
            ctl.data = '{KIND_DROP, ext_ff, tag_ff};
         end
         ST_CHAIN_ACT: begin
            ctl.emit = best_v_ff && (best_ff.seq == rel_next);
            ctl.data = '{KIND_RELEASE, best_ff.seq, best_ff.tag};
         end
         ST_SCAN_ACT: begin
            ctl.emit = best_v_ff && (tmo || (best_ff.seq == rel_next));
            ctl.data = '{KIND_RELEASE, best_ff.seq, best_ff.tag};
         end
         ST_SCAN_RPT: begin
            ctl.emit = rpt_ok;
            ctl.data = '{KIND_REPORT, best_ff.seq, best_ff.tag};
         end
         default: ctl.emit = 1'b0;
      endcase
   end

   assign stall = (ctl.emit || ctl.finish) && !q_ok;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_DECODE;
         ST_DECODE: begin
            if (op_ff == OP_TICK) begin
               state_in = ST_SWEEP;
            end else if (!started_ff) begin
               state_in = ST_RPT;
            end else if (udelta < DROPOUT_LIMIT) begin
               state_in = ST_CLASSIFY;
            end else if ({1'b0, udelta} <= MISORDER_BOUND) begin
               state_in = ({1'b0, seq_ff} == suspect_ff) ? ST_RPT : ST_FINISH;
            end else begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_RPT:      state_in = ST_REL_ITEM;
         ST_REL_ITEM: state_in = chain_ff ? ST_SWEEP : ST_FINISH;
         ST_CLASSIFY: begin
            if (rel_next == ext_ff)          state_in = ST_REL_ITEM;
            else if (ext_ff <= released_ff)  state_in = ST_FINISH;
            else                             state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               unique case (mode_ff)
                  SW_CHAIN:  state_in = ST_CHAIN_ACT;
                  SW_SCAN:   state_in = ST_SCAN_ACT;
                  SW_LOOKUP: state_in = ST_STORE;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_STORE:     state_in = (best_v_ff || free_v) ? ST_SWEEP : ST_FINISH;
         ST_CHAIN_ACT: state_in = ctl.emit ? ST_SWEEP : ST_FINISH;
         ST_SCAN_ACT: begin
            if (!best_v_ff) state_in = ST_FINISH;
            else if (tmo)   state_in = ST_SCAN_RPT;
            else            state_in = ST_SWEEP;
         end
         ST_SCAN_RPT: state_in = ST_SWEEP;
         ST_FINISH:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
      if (stall) state_in = state_ff;
   end

   // datapath and store updates
   always_comb begin
      started_in   = started_ff;
      highest_in   = highest_ff;
      suspect_in   = suspect_ff;
      wrap_in      = wrap_ff;
      released_in  = released_ff;
      last_rpt_in  = last_rpt_ff;
      valid_in     = valid_ff;
      ext_in       = ext_ff;
      chain_in     = chain_ff;
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      rdv_in       = rdv_ff;
      rdidx_in     = rdidx_ff;
      best_v_in    = best_v_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      use_bound_in = use_bound_ff;
      bound_in     = bound_ff;
      wr_en        = 1'b0;
      wr_idx       = best_idx_ff;
      wr_data      = '{ext_ff, tag_ff, now_ff};

      unique case (state_ff)
         ST_DECODE: begin
            chain_in = 1'b0;
            if (op_ff == OP_TICK) begin
               mode_in      = SW_SCAN;
               use_bound_in = 1'b0;
               cnt_in       = '0;
               rdv_in       = 1'b0;
               best_v_in    = 1'b0;
            end else if (!started_ff) begin
               started_in = 1'b1;
               highest_in = seq_ff;
               suspect_in = SUSPECT_RESET;
               wrap_in    = '0;
               ext_in     = {32'd0, seq_ff};
            end else if (udelta < DROPOUT_LIMIT) begin
               wrap_in    = wrap_new;
               highest_in = seq_ff;
               ext_in     = {wrap_new, seq_ff};
            end else if ({1'b0, udelta} <= MISORDER_BOUND) begin
               if ({1'b0, seq_ff} == suspect_ff) begin
                  highest_in = seq_ff;
                  suspect_in = SUSPECT_RESET;
                  wrap_in    = '0;
                  ext_in     = {32'd0, seq_ff};
               end else begin
                  suspect_in = {1'b0, seq_ff + 16'd1};
               end
            end else begin
               ext_in = {wrap_ff, seq_ff};
            end
         end
         ST_RPT: begin
            if (!stall && rpt_ok) last_rpt_in = now_ff;
         end
         ST_REL_ITEM: begin
            if (!stall) begin
               released_in  = ext_ff;
               mode_in      = SW_CHAIN;
               use_bound_in = 1'b0;
               cnt_in       = '0;
               rdv_in       = 1'b0;
               best_v_in    = 1'b0;
            end
         end
         ST_CLASSIFY: begin
            if (rel_next == ext_ff) begin
               chain_in = 1'b1;
            end else begin
               mode_in   = SW_LOOKUP;
               cnt_in    = '0;
               rdv_in    = 1'b0;
               best_v_in = 1'b0;
            end
         end
         ST_SWEEP: begin
            rdv_in   = rd_en;
            rdidx_in = cnt_ff[IW-1:0];
            if (rd_en) cnt_in = cnt_ff + CW'(1);
            if (rdv_ff && valid_ff[rdidx_ff]) begin
               if (mode_ff == SW_LOOKUP) begin
                  if (rd_ff.seq == ext_ff) begin
                     best_v_in   = 1'b1;
                     best_idx_in = rdidx_ff;
                  end
               end else if ((!use_bound_ff || (rd_ff.seq > bound_ff)) &&
                            (!best_v_ff || (rd_ff.seq < best_ff.seq))) begin
                  best_v_in   = 1'b1;
                  best_idx_in = rdidx_ff;
                  best_in     = rd_ff;
               end
            end
         end
         ST_STORE: begin
            if (best_v_ff || free_v) begin
               wr_en            = 1'b1;
               wr_idx           = best_v_ff ? best_idx_ff : free_idx;
               valid_in[wr_idx] = 1'b1;
               mode_in          = SW_SCAN;
               use_bound_in     = 1'b0;
               cnt_in           = '0;
               rdv_in           = 1'b0;
               best_v_in        = 1'b0;
            end
         end
         ST_CHAIN_ACT: begin
            if (ctl.emit && !stall) begin
               valid_in[best_idx_ff] = 1'b0;
               released_in           = best_ff.seq;
               cnt_in                = '0;
               rdv_in                = 1'b0;
               best_v_in             = 1'b0;
            end
         end
         ST_SCAN_ACT: begin
            if (best_v_ff && !stall) begin
               use_bound_in = 1'b1;
               bound_in     = best_ff.seq;
               if (ctl.emit) begin
                  valid_in[best_idx_ff] = 1'b0;
                  released_in           = best_ff.seq;
               end
               // a timed-out entry keeps best for its report
               if (!tmo) begin
                  cnt_in    = '0;
                  rdv_in    = 1'b0;
                  best_v_in = 1'b0;
               end
            end
         end
         ST_SCAN_RPT: begin
            if (!stall) begin
               if (rpt_ok) last_rpt_in = now_ff;
               cnt_in    = '0;
               rdv_in    = 1'b0;
               best_v_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) slot_mem[wr_idx] <= wr_data;
      if (rd_en) rd_ff <= slot_mem[cnt_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         started_ff  <= 1'b0;
         highest_ff  <= '0;
         suspect_ff  <= SUSPECT_RESET;
         wrap_ff     <= '0;
         released_ff <= '0;
         last_rpt_ff <= '0;
         timeout_ff  <= TIMEOUT_RESET;
         gap_ff      <= REPORT_GAP_RESET;
         valid_ff    <= '0;
         rdv_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         started_ff  <= started_in;
         highest_ff  <= highest_in;
         suspect_ff  <= suspect_in;
         wrap_ff     <= wrap_in;
         released_ff <= released_in;
         last_rpt_ff <= last_rpt_in;
         valid_ff    <= valid_in;
         rdv_ff      <= rdv_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TIMEOUT:    timeout_ff <= csr_wdata;
               CSR_REPORT_GAP: gap_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      if (accept) begin
         op_ff  <= req.operation;
         seq_ff <= req.seq;
         tag_ff <= req.packet_tag;
         now_ff <= req.now_ms;
      end
      ext_ff       <= ext_in;
      chain_ff     <= chain_in;
      mode_ff      <= mode_in;
      cnt_ff       <= cnt_in;
      rdidx_ff     <= rdidx_in;
      best_v_ff    <= best_v_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      use_bound_ff <= use_bound_in;
      bound_ff     <= bound_in;
   end

   rtpjb_emit_stage u_emit (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .ok    (q_ok),
      .rsp   (rsp)
   );

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DECODE)
      else $error("accepted transfer did not enter decode");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(state_ff))
      else $error("sequencer advanced while output was blocked");

   a_release_emits: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(released_ff)) |-> $past(ctl.emit && q_ok))
      else $error("released sequence moved without a result transfer");

   a_started_sticks: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag fell outside reset");

endmodule
`default_nettype wire

[tb/rtp_jitter_reorder_buffer_tb.sv]
// ----------------------------------------------------------------------------
// rtp_jitter_reorder_buffer_tb
// Drives packet and tick items through the jitter buffer, predicts released
// packets, loss reports and store-full drops, and checks every result field.
// ----------------------------------------------------------------------------
module rtp_jitter_reorder_buffer_tb;
   import rtpjb_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] ext_seq;
      logic [15:0] tag;
      logic        last;
   } rtp_result_type;

   class reorder_scoreboard;
      rtp_result_type pending[$];
      int             errors;
      logic [15:0]    timeout_ms;
      logic [15:0]    report_gap_ms;
      bit             started;
      logic [15:0]    highest_seq;
      logic [16:0]    suspect_seq;
      logic [31:0]    wrap_count;
      logic [47:0]    released_seq;
      logic [31:0]    last_report_ms;
      bit             held_valid[32];
      logic [47:0]    held_seq[32];
      logic [15:0]    held_tag[32];
      logic [31:0]    held_arrival[32];
      rtp_result_type batch[$];

      function new();
         timeout_ms = TIMEOUT_RESET;
         report_gap_ms = REPORT_GAP_RESET;
         started = 0;
         highest_seq = 0;
         suspect_seq = SUSPECT_RESET;
         wrap_count = 0;
         released_seq = 0;
         last_report_ms = 0;
         errors = 0;
         foreach (held_valid[i]) held_valid[i] = 0;
      endfunction

      function void set_reg(logic idx, logic [15:0] v);
         if (idx == CSR_TIMEOUT) timeout_ms = v;
         else report_gap_ms = v;
      endfunction

      function bit aged(logic [31:0] now_t, logic [31:0] then_t, logic [15:0] lim);
         logic [31:0] d;
         d = now_t - then_t;
         return !d[31] && d > {16'd0, lim};
      endfunction

      function void push(logic [1:0] k, logic [47:0] e, logic [15:0] t);
         rtp_result_type r;
         r.kind = k;
         r.ext_seq = e;
         r.tag = t;
         r.last = 0;
         batch.push_back(r);
      endfunction

      function void give_out(logic [47:0] e, logic [15:0] t);
         released_seq = e;
         push(KIND_RELEASE, e, t);
      endfunction

      function void loss_report(logic [47:0] e, logic [15:0] t, logic [31:0] now_t);
         if (aged(now_t, last_report_ms, report_gap_ms)) begin
            last_report_ms = now_t;
            push(KIND_REPORT, e, t);
         end
      endfunction

      function int lowest_above(bit bounded, logic [47:0] bound);
         int best;
         best = -1;
         for (int i = 0; i < 32; i++) begin
            if (!held_valid[i] || (bounded && held_seq[i] <= bound)) continue;
            if (best < 0 || held_seq[i] < held_seq[best]) best = i;
         end
         return best;
      endfunction

      function void sweep(logic [31:0] now_t);
         bit bounded;
         logic [47:0] bound;
         int i;
         bounded = 0;
         bound = 0;
         forever begin
            i = lowest_above(bounded, bound);
            if (i < 0) break;
            bounded = 1;
            bound = held_seq[i];
            if (aged(now_t, held_arrival[i], timeout_ms)) begin
               held_valid[i] = 0;
               give_out(held_seq[i], held_tag[i]);
               loss_report(held_seq[i], held_tag[i], now_t);
            end else if (released_seq + 48'd1 == held_seq[i]) begin
               held_valid[i] = 0;
               give_out(held_seq[i], held_tag[i]);
            end
         end
      endfunction

      function void restart(logic [15:0] s);
         highest_seq = s;
         suspect_seq = SUSPECT_RESET;
         wrap_count = 0;
      endfunction

      function void packet(logic [15:0] s, logic [15:0] t, logic [31:0] now_t);
         logic [15:0] udelta;
         logic [47:0] ext;
         int hit, free_i, j;
         if (!started) begin
            started = 1;
            restart(s);
            loss_report({32'd0, s}, t, now_t);
            give_out({32'd0, s}, t);
            return;
         end
         udelta = s - highest_seq;
         if (udelta < DROPOUT_LIMIT) begin
            if (s < highest_seq) wrap_count++;
            highest_seq = s;
         end else if ({1'b0, udelta} <= MISORDER_BOUND) begin
            if ({1'b0, s} == suspect_seq) begin
               restart(s);
               loss_report({32'd0, s}, t, now_t);
               give_out({32'd0, s}, t);
               return;
            end
            suspect_seq = {1'b0, s + 16'd1};
            return;
         end
         ext = {wrap_count, s};
         if (released_seq + 48'd1 == ext) begin
            give_out(ext, t);
            forever begin
               j = lowest_above(1'b0, 48'd0);
               if (j < 0 || held_seq[j] != released_seq + 48'd1) break;
               held_valid[j] = 0;
               give_out(held_seq[j], held_tag[j]);
            end
            return;
         end
         if (ext <= released_seq) return;
         hit = -1;
         free_i = -1;
         for (int i = 0; i < 32; i++) begin
            if (held_valid[i]) begin
               if (held_seq[i] == ext) hit = i;
            end else if (free_i < 0) free_i = i;
         end
         if (hit < 0) hit = free_i;
         if (hit < 0) begin
            push(KIND_DROP, ext, t);
            return;
         end
         held_valid[hit] = 1;
         held_seq[hit] = ext;
         held_tag[hit] = t;
         held_arrival[hit] = now_t;
         sweep(now_t);
      endfunction

      // note an accepted input and queue what it should produce
      function void note_input(logic op, logic [15:0] s, logic [15:0] t,
                               logic [31:0] now_t);
         batch.delete();
         if (op == OP_PACKET) packet(s, t, now_t);
         else sweep(now_t);
         if (batch.size() > 0) batch[batch.size() - 1].last = 1;
         foreach (batch[i]) pending.push_back(batch[i]);
      endfunction

      function void check_result(rtp_result_type got);
         rtp_result_type exp_r;
         if (pending.size() == 0) begin
            $error("unexpected result kind=%0d ext_seq=%0h", got.kind, got.ext_seq);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, got.kind);
            errors++;
         end
         if (got.ext_seq !== exp_r.ext_seq) begin
            $error("ext_seq: expected %0h, got %0h", exp_r.ext_seq, got.ext_seq);
            errors++;
         end
         if (got.tag !== exp_r.tag) begin
            $error("out_tag: expected %0h, got %0h", exp_r.tag, got.tag);
            errors++;
         end
         if (got.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic        csr_index = CSR_TIMEOUT;
   logic [15:0] csr_wdata = 0;
   longint      cycle_count = 0;
   bit          stall_mode = 0;
   logic [15:0] next_seq;
   logic [31:0] clock_ms;
   int          burst_left;

   rtpjb_req_if req();
   rtpjb_rsp_if rsp();
   reorder_scoreboard sb;

   rtp_jitter_reorder_buffer #(.STORE_DEPTH(32)) DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      req.valid = 0;
      req.operation = OP_TICK;
      req.seq = 0;
      req.packet_tag = 0;
      req.now_ms = 0;
      rsp.ready = 0;
   end

   // receiver stalls: free-running stretches alternate with random stalls
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 3000 == 0) stall_mode <= ~stall_mode;
      if (reset) rsp.ready <= 0;
      else rsp.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
      if (!reset && rsp.valid && rsp.ready)
         sb.check_result({rsp.kind, rsp.ext_seq, rsp.out_tag, rsp.last});
      if (cycle_count > 3000000) begin
         $display("rtp_jitter_reorder_buffer_tb NOT OK");
         $finish;
      end
   end

   // valid stays up after a transfer until the next item or a gap replaces it
   task automatic send(logic op, logic [15:0] s, logic [15:0] t, logic [31:0] now_t);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req.valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req.valid <= 1;
      req.operation <= op;
      req.seq <= s;
      req.packet_tag <= t;
      req.now_ms <= now_t;
      do @(posedge clock); while (!req.ready);
      sb.note_input(op, s, t, now_t);
   endtask

   task automatic drain();
      req.valid <= 0;
      burst_left = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (1300) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic pkt(logic [15:0] s, logic [31:0] dt);
      clock_ms += dt;
      send(OP_PACKET, s, 16'($urandom), clock_ms);
   endtask

   task automatic tick(logic [31:0] dt);
      clock_ms += dt;
      send(OP_TICK, 16'($urandom), 16'($urandom), clock_ms);
   endtask

   // well-formed stream with reordering, losses, duplicates and jumps
   task automatic random_phase(int n);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            pkt(16'(next_seq + $urandom_range(0, 4)), $urandom_range(0, 30));
            if ($urandom_range(0, 2) != 0) next_seq += 16'($urandom_range(1, 3));
         end else if (r < 70) begin
            pkt(16'(next_seq - $urandom_range(0, 120)), $urandom_range(0, 20));
         end else if (r < 82) tick($urandom_range(0, 400));
         else if (r < 88) begin
            next_seq += 16'($urandom_range(3000, 60000));
            pkt(next_seq, 5);
            if ($urandom_range(0, 1)) begin
               next_seq += 16'd1;
               pkt(next_seq, 5);
            end
            next_seq += 16'd1;
         end else if (r < 94) pkt(16'($urandom), $urandom_range(0, 50));
         else begin
            clock_ms += $urandom;
            send(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), clock_ms);
         end
      end
   endtask

   initial begin
      sb = new();
      burst_left = 0;
      clock_ms = 32'hFFFF_FF00;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: tick before start, first packet, wrap, fill the store
      tick(1000);
      pkt(16'hFFFE, 600);
      pkt(16'hFFFF, 1);
      pkt(16'h0000, 1);
      pkt(16'h0000, 1);
      pkt(16'h0003, 1);
      pkt(16'h0003, 1);
      pkt(16'h0002, 1);
      pkt(16'h0001, 1);
      pkt(16'h0000, 1);
      for (int i = 0; i < 34; i++) pkt(16'd10 + 16'(2 * i), 0);
      tick(101);
      pkt(16'd40000, 600);
      pkt(16'd40001, 1);
      drain();

      write_reg(CSR_TIMEOUT, 16'd1);
      write_reg(CSR_REPORT_GAP, 16'd0);
      next_seq = 16'd40002;
      random_phase(100);
      drain();

      write_reg(CSR_TIMEOUT, 16'hFFFF);
      write_reg(CSR_REPORT_GAP, 16'hFFFF);
      random_phase(100);
      drain();

      write_reg(CSR_TIMEOUT, 16'd60);
      write_reg(CSR_REPORT_GAP, 16'd200);
      random_phase(100);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("rtp_jitter_reorder_buffer_tb OK");
      else
         $display("rtp_jitter_reorder_buffer_tb NOT OK");
      $finish;
   end
endmodule
